// File: rtl/ecmb_pkg.sv
// shared types, constants and arithmetic helpers for the camera matrix builder
package ecmb_pkg;

    localparam int unsigned PosW  = 28;
    localparam int unsigned AngW  = 16;
    localparam int unsigned OrdW  = 3;
    localparam int unsigned EntW  = 32;

    localparam logic signed [18:0] Q16One = 19'sd65536;

    localparam logic [16:0] SinC1 = 17'd102944;
    localparam logic [16:0] SinC3 = 17'd42334;
    localparam logic [16:0] SinC5 = 17'd5223;
    localparam logic [16:0] SinC7 = 17'd297;

    // rotation multiply orders
    typedef enum logic [2:0] {
        ORD_XYZ = 3'd0,
        ORD_YXZ = 3'd1,
        ORD_XZY = 3'd2,
        ORD_YZX = 3'd3,
        ORD_ZYX = 3'd4,
        ORD_ZXY = 3'd5
    } t_ord;

    // 3x3 matrix of q16 entries, fits [-2^18, 2^18)
    typedef logic signed [18:0] t_m3 [3][3];

    // position and order fields of an input beat
    typedef struct packed {
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic signed [PosW-1:0] pos_z;
        logic [OrdW-1:0]        rot_order;
    } t_side;

    // round-half-up q16: (v + 32768) >> 16 arithmetic equals the floor form
    function automatic logic signed [47:0] rnd48(input logic signed [63:0] v);
        logic signed [63:0] w;
        w = v + 64'sd32768;
        return w[63:16];
    endfunction

    function automatic logic signed [EntW-1:0] sat32(input logic signed [47:0] v);
        if (v > 48'sd2147483647) return 32'sh7fffffff;
        else if (v < -48'sd2147483648) return 32'sh80000000;
        else return v[31:0];
    endfunction

endpackage

// File: rtl/ecmb_sincos.sv
// pipelined polynomial sine, four register stages
module ecmb_sincos
    import ecmb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [AngW-1:0]        i_ang,
    output logic signed [17:0]     o_sin
);
    logic [1:0]  r_q1, r_q2, r_q3, r_q4;
    logic [16:0] r_t1, r_t2, r_t3, r_t4;
    logic [16:0] r_t21, r_t22, r_t23;
    logic [16:0] r_p2, r_p3, r_p4;
    logic [14:0] n_u;
    logic [16:0] n_t;
    logic [33:0] n_sq, n_m2, n_m3, n_m4, n_m5;
    logic [16:0] n_p2, n_p3, n_p4;

    // stage 1: fold quadrant and square
    always_comb begin
        n_u  = i_ang[14] ? (15'd16384 - {1'b0, i_ang[13:0]}) : {1'b0, i_ang[13:0]};
        n_t  = {n_u, 2'b00};
        n_sq = n_t * n_t;
    end
    // stage 2..4: horner steps
    always_comb begin
        n_m2 = r_t21 * SinC7;
        n_p2 = SinC5 - n_m2[32:16];
        n_m3 = r_t22 * r_p2;
        n_p3 = SinC3 - n_m3[32:16];
        n_m4 = r_t23 * r_p3;
        n_p4 = SinC1 - n_m4[32:16];
        n_m5 = r_t4 * r_p4;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1 <= i_ang[15:14]; r_t1 <= n_t; r_t21 <= n_sq[32:16];
            r_q2 <= r_q1; r_t2 <= r_t1; r_t22 <= r_t21; r_p2 <= n_p2;
            r_q3 <= r_q2; r_t3 <= r_t2; r_t23 <= r_t22; r_p3 <= n_p3;
            r_q4 <= r_q3; r_t4 <= r_t3; r_p4 <= n_p4;
        end
    end

    assign o_sin = r_q4[1] ? -$signed({1'b0, n_m5[32:16]}) : $signed({1'b0, n_m5[32:16]});
endmodule

// File: rtl/ecmb_matmul.sv
// registered 3x3 q16 matrix product, one multiply stage and one sum stage
module ecmb_matmul
    import ecmb_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_m3  i_a,
    input  t_m3  i_b,
    output t_m3  o_r
);
    logic signed [37:0] r_pp [3][3][3];
    t_m3 r_r;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    for (int k = 0; k < 3; k++)
                        r_pp[i][j][k] <= i_a[i][k] * i_b[k][j];
        end
    end

    // sum and round, result fits 19 bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    r_r[i][j] <= 19'(rnd48(64'(r_pp[i][j][0]) + 64'(r_pp[i][j][1])
                                           + 64'(r_pp[i][j][2])));
        end
    end

    assign o_r = r_r;
endmodule

// File: rtl/euler_camera_matrix_builder.sv
// top level: angle pipeline, rotation products, translation row and row serializer
// Builds a 4x4 row-vector world-to-camera matrix per input beat and sends it as
// four output beats, row 0 first, tlast on row 3. The datapath is a 12-stage
// pipeline that takes one beat per cycle unless stalled; the output serializer
// emits one row per cycle while m_axis_tready is high and loads the next matrix as
// row 3 is taken. The pipeline stalls as a whole while the serializer is full.
module euler_camera_matrix_builder
    import ecmb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x[27:0], pos_y[55:28], pos_z[83:56], angle_x[99:84], angle_y[115:100],
    // angle_z[131:116], rot_order[134:132], zero fill
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // row_index[1:0], col0[33:2], col1[65:34], col2[97:66], col3[129:98], zero fill
    output logic [135:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    localparam int unsigned Lat = 12;

    logic         n_en;
    logic [Lat-1:0] r_vld;
    t_side        r_sd [Lat-2];
    logic signed [17:0] w_sin [3], w_cos [3];
    t_m3 r_mx, r_my, r_mz, w_a, w_b, w_c, w_ab, r_c1, r_c2, w_rot, r_rot, n_rot;
    t_side w_s6, w_s9, w_s10;
    logic signed [46:0] r_tp [3][3];
    logic signed [EntW-1:0] r_tr [3];
    t_m3 r_rot2;
    // serializer
    logic         r_full;
    logic [1:0]   r_row;
    logic signed [EntW-1:0] r_out [4][4];

    assign n_en = !r_full || (m_axis_tready && r_row == 2'd3);
    assign s_axis_tready = n_en;

    // valid and side pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[Lat-2:0], s_axis_tvalid};
        end
    end
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_sd[0] <= {s_axis_tdata[27:0], s_axis_tdata[55:28], s_axis_tdata[83:56],
                        s_axis_tdata[134:132]};
            for (int i = 1; i < Lat-2; i++) r_sd[i] <= r_sd[i-1];
        end
    end

    // sine and cosine units, stages 1..4
    for (genvar g = 0; g < 3; g++) begin : g_trig
        logic [AngW-1:0] w_ang;
        assign w_ang = s_axis_tdata[84+16*g +: 16];
        ecmb_sincos u_sin (.i_clk, .i_en(n_en), .i_ang(w_ang), .o_sin(w_sin[g]));
        ecmb_sincos u_cos (.i_clk, .i_en(n_en), .i_ang(w_ang + 16'd16384),
                           .o_sin(w_cos[g]));
    end

    // stage 5: build inverse axis rotations (s = -sin)
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_mx <= '{'{Q16One, '0, '0}, '{'0, 19'(w_cos[0]), -19'(w_sin[0])},
                      '{'0, 19'(w_sin[0]), 19'(w_cos[0])}};
            r_my <= '{'{19'(w_cos[1]), '0, 19'(w_sin[1])}, '{'0, Q16One, '0},
                      '{-19'(w_sin[1]), '0, 19'(w_cos[1])}};
            r_mz <= '{'{19'(w_cos[2]), -19'(w_sin[2]), '0},
                      '{19'(w_sin[2]), 19'(w_cos[2]), '0}, '{'0, '0, Q16One}};
        end
    end

    // operand select by order
    assign w_s6 = r_sd[4];
    always_comb begin
        w_a = r_mx; w_b = r_my; w_c = r_mz;
        unique case (w_s6.rot_order)
            ORD_XYZ: begin w_a = r_mx; w_b = r_my; w_c = r_mz; end
            ORD_YXZ: begin w_a = r_my; w_b = r_mx; w_c = r_mz; end
            ORD_XZY: begin w_a = r_mx; w_b = r_mz; w_c = r_my; end
            ORD_YZX: begin w_a = r_my; w_b = r_mz; w_c = r_mx; end
            ORD_ZYX: begin w_a = r_mz; w_b = r_my; w_c = r_mx; end
            ORD_ZXY: begin w_a = r_mz; w_b = r_mx; w_c = r_my; end
            default: ;
        endcase
    end

    // stages 6,7: first product; third operand delayed alongside
    ecmb_matmul u_mm1 (.i_clk, .i_en(n_en), .i_a(w_a), .i_b(w_b), .o_r(w_ab));
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_c1 <= w_c;
            r_c2 <= r_c1;
        end
    end
    // stages 8,9: second product
    ecmb_matmul u_mm2 (.i_clk, .i_en(n_en), .i_a(w_ab), .i_b(r_c2), .o_r(w_rot));

    // identity for unknown orders
    assign w_s9 = r_sd[8];
    always_comb begin
        n_rot = w_rot;
        if (w_s9.rot_order > 3'(ORD_ZXY))
            n_rot = '{'{Q16One, '0, '0}, '{'0, Q16One, '0}, '{'0, '0, Q16One}};
    end

    // stage 10: rotation register, stage 11: translation products, stage 12: sums
    assign w_s10 = r_sd[9];
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_rot <= n_rot;
            for (int j = 0; j < 3; j++) begin
                r_tp[0][j] <= w_s10.pos_x * r_rot[0][j];
                r_tp[1][j] <= w_s10.pos_y * r_rot[1][j];
                r_tp[2][j] <= w_s10.pos_z * r_rot[2][j];
                r_tr[j] <= sat32(rnd48(-(64'(r_tp[0][j]) + 64'(r_tp[1][j])
                                         + 64'(r_tp[2][j]))));
            end
            r_rot2 <= r_rot;
        end
    end

    // row serializer: loads a full matrix, sends one row a beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_row  <= 2'd0;
        end else if (n_en) begin
            r_full <= r_vld[Lat-1];
            r_row  <= 2'd0;
        end else if (m_axis_tready) begin
            r_row <= r_row + 2'd1;
        end
    end
    t_m3 r_rot3;
    always_ff @(posedge i_clk) begin
        if (n_en) r_rot3 <= r_rot2;
    end
    always_ff @(posedge i_clk) begin
        if (n_en && r_vld[Lat-1]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) r_out[i][j] <= EntW'(r_rot3[i][j]);
                r_out[i][3] <= '0;
                r_out[3][i] <= r_tr[i];
            end
            r_out[3][3] <= 32'sd65536;
        end
    end

    assign m_axis_tvalid = r_full;
    assign m_axis_tlast  = (r_row == 2'd3);
    assign m_axis_tdata  = {6'd0, r_out[r_row][3], r_out[r_row][2], r_out[r_row][1],
                            r_out[r_row][0], r_row};
endmodule
